// ===== rtl/otsu_pkg.sv =====
// ---------------------------------------------------------------------------
// otsu_pkg: shared types and constants for the Otsu threshold selector
// Sizes of counts, sums and products, the queue entry and the back-end
// state encoding.
// ---------------------------------------------------------------------------
package otsu_pkg;

  // Pixel count width and derived datapath widths
  localparam int unsigned PIXEL_COUNT_BITS = 20;
  localparam int unsigned LVL_BITS   = 8;
  localparam int unsigned LEVELS     = 256;
  localparam int unsigned LAST_LEVEL = LEVELS - 2;
  localparam int unsigned SUM_BITS   = PIXEL_COUNT_BITS + LVL_BITS;
  localparam int unsigned XW         = PIXEL_COUNT_BITS + SUM_BITS;
  localparam int unsigned NUM_W      = 2 * XW;
  localparam int unsigned DEN_W      = 2 * PIXEL_COUNT_BITS;
  localparam int unsigned MA_W       = NUM_W;
  localparam int unsigned MB_W       = XW;
  localparam int unsigned PROD_W     = MA_W + MB_W;
  localparam int unsigned MCNT_W     = $clog2(MB_W + 1);

  // Front-to-back queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [LVL_BITS-1:0] gray_level;
    logic                last_pixel;
  } otsu_in_t;

  typedef struct packed {
    logic [LVL_BITS-1:0] threshold;
    logic                no_split;
    logic                overflow;
  } otsu_out_t;

  // Classified pixel; totals are valid on the last pixel only
  typedef struct packed {
    logic [LVL_BITS-1:0]         level;
    logic                        counted;
    logic                        last;
    logic [PIXEL_COUNT_BITS-1:0] total;
    logic [SUM_BITS-1:0]         level_sum;
    logic                        ovf;
  } otsu_qent_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_RUN,
    BK_DRAIN,
    BK_READ,
    BK_ACC,
    BK_CHECK,
    BK_MUL_X,
    BK_MUL_Y,
    BK_MUL_NUM,
    BK_MUL_DEN,
    BK_MUL_L,
    BK_MUL_R,
    BK_OUT
  } back_state_e;

endpackage

// ===== rtl/otsu_mul.sv =====
// ---------------------------------------------------------------------------
// otsu_mul: shared shift-and-add multiplier
// One multiplier bit per cycle; done pulses one cycle when the product is
// ready and the product holds until the next start.
// ---------------------------------------------------------------------------
module otsu_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [otsu_pkg::MA_W-1:0]    a_i,
  input  logic [otsu_pkg::MB_W-1:0]    b_i,
  output logic                         done_o,
  output logic [otsu_pkg::PROD_W-1:0]  prod_o
);

  logic [otsu_pkg::PROD_W-1:0] a_q, a_d, acc_q, acc_d;
  logic [otsu_pkg::MB_W-1:0]   b_q, b_d;
  logic [otsu_pkg::MCNT_W-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;

  // Step logic
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = otsu_pkg::PROD_W'(a_i);
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = otsu_pkg::MCNT_W'(otsu_pkg::MB_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - otsu_pkg::MCNT_W'(1);
      if (cnt_q == otsu_pkg::MCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/otsu_fifo.sv =====
// ---------------------------------------------------------------------------
// otsu_fifo: short queue between front and back end
// Register-based, first-word visible on the read port.
// ---------------------------------------------------------------------------
module otsu_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  otsu_pkg::otsu_qent_t  wdata_i,
  output logic                  full_o,
  input  logic                  rd_i,
  output logic                  empty_o,
  output otsu_pkg::otsu_qent_t  rdata_o
);

  otsu_pkg::otsu_qent_t          entries_q [otsu_pkg::FIFO_DEPTH];
  logic [otsu_pkg::FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [otsu_pkg::FIFO_AW:0]    count_q, count_d;

  assign full_o  = (count_q == (otsu_pkg::FIFO_AW+1)'(otsu_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = entries_q[rd_ptr_q];

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (wr_i && !rd_i) begin
      count_d = count_q + (otsu_pkg::FIFO_AW+1)'(1);
    end else if (rd_i && !wr_i) begin
      count_d = count_q - (otsu_pkg::FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + otsu_pkg::FIFO_AW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + otsu_pkg::FIFO_AW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/otsu_front.sv =====
// ---------------------------------------------------------------------------
// otsu_front: pixel intake and classification
// Checks capacity, keeps the running count, level sum and drop flag, and
// hands each pixel to the queue with the image totals on the last one.
// ---------------------------------------------------------------------------
module otsu_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  otsu_pkg::otsu_in_t    pixel_i,
  input  logic                  q_full_i,
  output logic                  q_wr_o,
  output otsu_pkg::otsu_qent_t  q_entry_o
);

  logic [otsu_pkg::PIXEL_COUNT_BITS-1:0] total_q, total_d;
  logic [otsu_pkg::SUM_BITS-1:0]         sum_q, sum_d;
  logic                                  ovf_q, ovf_d;
  logic                                  counted;

  assign q_wr_o  = push_i && !q_full_i;
  // Count saturates at all ones; beyond that pixels are dropped
  assign counted = (total_q != '1);

  // Classified entry
  always_comb begin
    q_entry_o.level     = pixel_i.gray_level;
    q_entry_o.counted   = counted;
    q_entry_o.last      = pixel_i.last_pixel;
    q_entry_o.total     = total_q + otsu_pkg::PIXEL_COUNT_BITS'(counted);
    q_entry_o.level_sum = counted ? sum_q + otsu_pkg::SUM_BITS'(pixel_i.gray_level) : sum_q;
    q_entry_o.ovf       = ovf_q || !counted;
  end

  // Running totals, cleared after the last pixel
  always_comb begin
    total_d = total_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    if (q_wr_o) begin
      if (pixel_i.last_pixel) begin
        total_d = '0;
        sum_d   = '0;
        ovf_d   = 1'b0;
      end else begin
        total_d = q_entry_o.total;
        sum_d   = q_entry_o.level_sum;
        ovf_d   = q_entry_o.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      total_q <= total_d;
      sum_q   <= sum_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ===== rtl/otsu_back.sv =====
// ---------------------------------------------------------------------------
// otsu_back: histogram memory, threshold scan and result register
// Counts queued pixels into the bin memory, scans levels with the shared
// multiplier, presents the result and clears the memory again.
// ---------------------------------------------------------------------------
module otsu_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  otsu_pkg::otsu_qent_t  q_entry_i,
  output logic                  q_rd_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output otsu_pkg::otsu_out_t   result_o
);

  localparam int unsigned PB = otsu_pkg::PIXEL_COUNT_BITS;
  localparam int unsigned LB = otsu_pkg::LVL_BITS;

  otsu_pkg::back_state_e state_q, state_d;

  // Bin memory with registered read and write-through bypass
  logic [PB-1:0] bin_mem [otsu_pkg::LEVELS];
  logic          we;
  logic [LB-1:0] wa, ra;
  logic [PB-1:0] wd, rd_q, byp_data_q, cnt_src;
  logic          byp_q;
  logic          bval_q;
  logic [LB-1:0] baddr_q;

  // Scan registers
  logic [LB-1:0]                 t_q, t_d;
  logic [PB-1:0]                 n_q, n_d, c_q, c_d, nc;
  logic [otsu_pkg::SUM_BITS-1:0] tot_q, tot_d, s_q, s_d;
  logic                          ovf_q, ovf_d;
  logic [otsu_pkg::XW-1:0]       x_q, x_d, y, diff;
  logic [otsu_pkg::NUM_W-1:0]    num_q, num_d, best_num_q, best_num_d;
  logic [otsu_pkg::DEN_W-1:0]    den_q, den_d, best_den_q, best_den_d;
  logic [otsu_pkg::PROD_W-1:0]   l_q, l_d;
  logic [LB-1:0]                 best_t_q, best_t_d;
  logic                          found_q, found_d;
  logic                          out_valid_q, out_valid_d;
  otsu_pkg::otsu_out_t           out_q, out_d;

  // Multiplier hookup
  logic                         mul_start, mul_done;
  logic [otsu_pkg::MA_W-1:0]    mul_a;
  logic [otsu_pkg::MB_W-1:0]    mul_b;
  logic [otsu_pkg::PROD_W-1:0]  prod;

  logic split_ok, last_lvl, out_free, pix_pop;

  otsu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign cnt_src  = byp_q ? byp_data_q : rd_q;
  assign nc       = n_q - c_q;
  assign split_ok = (c_q != '0) && (c_q != n_q);
  assign last_lvl = (t_q == LB'(otsu_pkg::LAST_LEVEL));
  assign out_free = !out_valid_q || pop_i;
  assign y        = prod[otsu_pkg::XW-1:0];
  assign diff     = (x_q >= y) ? x_q - y : y - x_q;
  assign pix_pop  = (state_q == otsu_pkg::BK_RUN) && !q_empty_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      otsu_pkg::BK_CLEAR: begin
        if (t_q == LB'(otsu_pkg::LEVELS - 1)) state_d = otsu_pkg::BK_RUN;
      end
      otsu_pkg::BK_RUN: begin
        if (pix_pop && q_entry_i.last) state_d = otsu_pkg::BK_DRAIN;
      end
      otsu_pkg::BK_DRAIN: state_d = otsu_pkg::BK_READ;
      otsu_pkg::BK_READ:  state_d = otsu_pkg::BK_ACC;
      otsu_pkg::BK_ACC:   state_d = otsu_pkg::BK_CHECK;
      otsu_pkg::BK_CHECK: begin
        if (split_ok)      state_d = otsu_pkg::BK_MUL_X;
        else if (last_lvl) state_d = otsu_pkg::BK_OUT;
        else               state_d = otsu_pkg::BK_READ;
      end
      otsu_pkg::BK_MUL_X:   if (mul_done) state_d = otsu_pkg::BK_MUL_Y;
      otsu_pkg::BK_MUL_Y:   if (mul_done) state_d = otsu_pkg::BK_MUL_NUM;
      otsu_pkg::BK_MUL_NUM: if (mul_done) state_d = otsu_pkg::BK_MUL_DEN;
      otsu_pkg::BK_MUL_DEN: if (mul_done) state_d = otsu_pkg::BK_MUL_L;
      otsu_pkg::BK_MUL_L:   if (mul_done) state_d = otsu_pkg::BK_MUL_R;
      otsu_pkg::BK_MUL_R: begin
        if (mul_done) state_d = last_lvl ? otsu_pkg::BK_OUT : otsu_pkg::BK_READ;
      end
      otsu_pkg::BK_OUT: if (out_free) state_d = otsu_pkg::BK_CLEAR;
      default: state_d = otsu_pkg::BK_CLEAR;
    endcase
  end

  // Control outputs: queue read, memory port, multiplier start and operands
  always_comb begin
    q_rd_o    = pix_pop;
    we        = 1'b0;
    wa        = t_q;
    wd        = '0;
    ra        = t_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    if (bval_q) begin
      we = 1'b1;
      wa = baddr_q;
      wd = cnt_src + PB'(1);
    end
    unique case (state_q)
      otsu_pkg::BK_CLEAR: we = 1'b1;
      otsu_pkg::BK_RUN:   ra = q_entry_i.level;
      otsu_pkg::BK_CHECK: begin
        mul_start = split_ok;
        mul_a     = otsu_pkg::MA_W'(tot_q);
        mul_b     = otsu_pkg::MB_W'(c_q);
      end
      otsu_pkg::BK_MUL_X: begin
        mul_start = mul_done;
        mul_a     = otsu_pkg::MA_W'(n_q);
        mul_b     = otsu_pkg::MB_W'(s_q);
      end
      otsu_pkg::BK_MUL_Y: begin
        mul_start = mul_done;
        mul_a     = otsu_pkg::MA_W'(diff);
        mul_b     = diff;
      end
      otsu_pkg::BK_MUL_NUM: begin
        mul_start = mul_done;
        mul_a     = otsu_pkg::MA_W'(c_q);
        mul_b     = otsu_pkg::MB_W'(nc);
      end
      otsu_pkg::BK_MUL_DEN: begin
        mul_start = mul_done;
        mul_a     = num_q;
        mul_b     = otsu_pkg::MB_W'(best_den_q);
      end
      otsu_pkg::BK_MUL_L: begin
        mul_start = mul_done;
        mul_a     = best_num_q;
        mul_b     = otsu_pkg::MB_W'(den_q);
      end
      default: ;
    endcase
  end

  // Datapath register updates
  always_comb begin
    t_d         = t_q;
    n_d         = n_q;
    tot_d       = tot_q;
    ovf_d       = ovf_q;
    c_d         = c_q;
    s_d         = s_q;
    x_d         = x_q;
    num_d       = num_q;
    den_d       = den_q;
    l_d         = l_q;
    best_num_d  = best_num_q;
    best_den_d  = best_den_q;
    best_t_d    = best_t_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    unique case (state_q)
      otsu_pkg::BK_CLEAR: t_d = t_q + LB'(1);
      otsu_pkg::BK_RUN: begin
        if (pix_pop && q_entry_i.last) begin
          n_d   = q_entry_i.total;
          tot_d = q_entry_i.level_sum;
          ovf_d = q_entry_i.ovf;
        end
      end
      otsu_pkg::BK_DRAIN: begin
        t_d     = '0;
        c_d     = '0;
        s_d     = '0;
        found_d = 1'b0;
      end
      otsu_pkg::BK_ACC: begin
        c_d = c_q + rd_q;
        s_d = s_q + otsu_pkg::SUM_BITS'(t_q) * otsu_pkg::SUM_BITS'(rd_q);
      end
      otsu_pkg::BK_CHECK: begin
        if (!split_ok && !last_lvl) t_d = t_q + LB'(1);
      end
      otsu_pkg::BK_MUL_X:   if (mul_done) x_d = prod[otsu_pkg::XW-1:0];
      otsu_pkg::BK_MUL_NUM: if (mul_done) num_d = prod[otsu_pkg::NUM_W-1:0];
      otsu_pkg::BK_MUL_DEN: if (mul_done) den_d = prod[otsu_pkg::DEN_W-1:0];
      otsu_pkg::BK_MUL_L:   if (mul_done) l_d = prod;
      otsu_pkg::BK_MUL_R: begin
        if (mul_done) begin
          // strict improvement over the best fraction so far
          if (!found_q || (l_q > prod)) begin
            found_d    = 1'b1;
            best_t_d   = t_q;
            best_num_d = num_q;
            best_den_d = den_q;
          end
          if (!last_lvl) t_d = t_q + LB'(1);
        end
      end
      otsu_pkg::BK_OUT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.threshold = found_q ? best_t_q : '0;
          out_d.no_split  = !found_q;
          out_d.overflow  = ovf_q;
          t_d            = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= otsu_pkg::BK_CLEAR;
      t_q         <= '0;
      bval_q      <= 1'b0;
      byp_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      bval_q      <= pix_pop && q_entry_i.counted;
      byp_q       <= we && (wa == ra);
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    baddr_q    <= q_entry_i.level;
    byp_data_q <= wd;
    n_q        <= n_d;
    tot_q      <= tot_d;
    ovf_q      <= ovf_d;
    c_q        <= c_d;
    s_q        <= s_d;
    x_q        <= x_d;
    num_q      <= num_d;
    den_q      <= den_d;
    l_q        <= l_d;
    best_num_q <= best_num_d;
    best_den_q <= best_den_d;
    best_t_q   <= best_t_d;
    out_q      <= out_d;
  end

  // Bin memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      bin_mem[wa] <= wd;
    end
    rd_q <= bin_mem[ra];
  end

  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

endmodule

// ===== rtl/otsu_threshold_select.sv =====
// ---------------------------------------------------------------------------
// otsu_threshold_select: Otsu threshold selection for 8-bit gray images
// Pixels enter through a queue-style port (push/full) and one result per
// image leaves through a queue-style port (empty/pop).
// ---------------------------------------------------------------------------
// Usage:
// - Push one pixel per cycle; mark the final pixel of the image with
//   last_pixel. Pixels beyond 2^20-1 per image are dropped and flagged.
// - Pixels stream into the histogram at one per cycle through a 4-entry
//   queue. While a scan or memory clear runs, the queue fills and full rises.
// - After the last pixel the scan visits levels 0..254. A level with no valid
//   split only reads and accumulates its bin; a valid one also forms six
//   products on the shared bit-serial 96x48 multiplier.
// - The result stays on result_o while empty is low until popped; a stalled
//   receiver only holds the scan at its final step.
// - After each result, and after reset, the 256-entry bin memory is cleared
//   one entry a cycle; pixels wait in the queue meanwhile.
// ---------------------------------------------------------------------------
module otsu_threshold_select (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  otsu_pkg::otsu_in_t   pixel_i,
  output logic                 empty,
  input  logic                 pop,
  output otsu_pkg::otsu_out_t  result_o
);

  otsu_pkg::otsu_qent_t wr_entry, rd_entry;
  logic                 q_wr, q_rd, q_full, q_empty;

  assign full = q_full;

  otsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pixel_i   (pixel_i),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_entry_o (wr_entry)
  );

  otsu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (wr_entry),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .rdata_o (rd_entry)
  );

  otsu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_entry_i (rd_entry),
    .q_rd_o    (q_rd),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (result_o)
  );

endmodule

// ===== rtl/otsu_checker.sv =====
// ---------------------------------------------------------------------------
// otsu_checker: port-level checks for the threshold selector
// Watches the result channel and the pixel port over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
module otsu_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input otsu_pkg::otsu_in_t   pixel_i,
  input logic                 empty,
  input logic                 pop,
  input otsu_pkg::otsu_out_t  result_o
);

  // A waiting result holds until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("result changed while waiting");

  // No valid split reports threshold zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.no_split |-> result_o.threshold == '0)
    else $error("no_split with nonzero threshold");

  // Scan never reaches the top level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> result_o.threshold != 8'hFF)
    else $error("threshold out of range");

  // A waiting result carries known fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !$isunknown(result_o))
    else $error("result has unknown bits");

  // An accepted pixel carries known fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |-> !$isunknown(pixel_i))
    else $error("pixel has unknown bits");

endmodule

bind otsu_threshold_select otsu_checker u_otsu_checker (.*);
